[design/spi_cmd_data_master_defines.svh]
// ----------------------------------------------------------------------------
// spi_cmd_data_master assertion macros
// concurrent checks, with or without a reset qualifier, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef SPI_CMD_DATA_MASTER_DEFINES_SVH
`define SPI_CMD_DATA_MASTER_DEFINES_SVH

`ifndef SYNTHESIS
`define SCDM_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scdm assertion failed");
`define SCDM_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("scdm assertion failed");
`else
`define SCDM_ASSERT(label, clk, rst_n, prop)
`define SCDM_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[design/scdm_pkg.sv]
// ----------------------------------------------------------------------------
// scdm_pkg
// shared constants and the result record of the spi command/data master
// ----------------------------------------------------------------------------
package scdm_pkg;

    localparam int CMD_BITS = 8;
    localparam int WORD_W   = 16;

    typedef struct packed {
        logic              sclk;
        logic              mosi;
        logic              cs_cmd_n;
        logic              cs_data_n;
        logic              busy_res;
        logic              done_res;
        logic [WORD_W-1:0] read_word;
    } t_result;

endpackage

[design/spi_cmd_data_master.sv]
// ----------------------------------------------------------------------------
// spi_cmd_data_master
// bit-level spi master, one tick per request, command byte then data word
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  input     i_in_valid / o_in_ready    start_req, mode, cmd_byte, write_word, miso
//  output    o_out_valid / i_out_ready  sclk, mosi, cs_cmd_n, cs_data_n, busy,
//                                       done, read_word
//
//  one request per clock while o_in_ready is high; its result is registered in the output buffer
//  a transaction runs the command bits, a gap request, the write or read data bits, then a finish request
//  output stall: a skid slot takes one more request, then o_in_ready drops
//  synchronous active-low reset returns the engine to idle, buffers empty
// ----------------------------------------------------------------------------
module spi_cmd_data_master import scdm_pkg::*; #(
    parameter int DATA_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_start_req,
    input  logic                i_mode,
    input  logic [CMD_BITS-1:0] i_cmd_byte,
    input  logic [WORD_W-1:0]   i_write_word,
    input  logic                i_miso,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_sclk,
    output logic                o_mosi,
    output logic                o_cs_cmd_n,
    output logic                o_cs_data_n,
    output logic                o_busy_res,
    output logic                o_done_res,
    output logic [WORD_W-1:0]   o_read_word
);

    logic    accept;
    t_result eng_result;
    t_result out_result;

    assign accept = i_in_valid && o_in_ready;

    scdm_engine #(
        .DATA_BITS (DATA_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_start_req  (i_start_req),
        .i_mode       (i_mode),
        .i_cmd_byte   (i_cmd_byte),
        .i_write_word (i_write_word),
        .i_miso       (i_miso),
        .o_result     (eng_result)
    );

    scdm_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept),
        .i_data     (eng_result),
        .o_can_push (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (out_result)
    );

    assign o_sclk      = out_result.sclk;
    assign o_mosi      = out_result.mosi;
    assign o_cs_cmd_n  = out_result.cs_cmd_n;
    assign o_cs_data_n = out_result.cs_data_n;
    assign o_busy_res  = out_result.busy_res;
    assign o_done_res  = out_result.done_res;
    assign o_read_word = out_result.read_word;

endmodule

[design/scdm_engine.sv]
// ----------------------------------------------------------------------------
// scdm_engine
// per-tick bit engine: transaction state plus next-state and pin logic
// ----------------------------------------------------------------------------
`include "spi_cmd_data_master_defines.svh"

module scdm_engine import scdm_pkg::*; #(
    parameter int DATA_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic                   i_start_req,
    input  logic                   i_mode,
    input  logic [CMD_BITS-1:0]    i_cmd_byte,
    input  logic [WORD_W-1:0]      i_write_word,
    input  logic                   i_miso,
    output t_result                o_result
);

    localparam int CNT_W = $clog2(DATA_BITS + 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CMD,
        PH_GAP,
        PH_WR,
        PH_RD,
        PH_FIN
    } t_phase;

    t_phase                r_phase,      n_phase;
    logic [CNT_W-1:0]      r_bit_count,  n_bit_count;
    logic                  r_half_tick,  n_half_tick;
    logic                  r_read_mode,  n_read_mode;
    logic [CMD_BITS-1:0]   r_cmd_shift,  n_cmd_shift;
    logic [DATA_BITS-1:0]  r_data_shift, n_data_shift;
    logic                  r_clk_level,  n_clk_level;
    logic                  r_mosi,       n_mosi;

    logic [CNT_W-1:0]             cnt_inc;
    logic [DATA_BITS+WORD_W-1:0]  wr_wide;
    logic [DATA_BITS+WORD_W-1:0]  rd_wide;
    logic [DATA_BITS-1:0]         wr_fit;

    assign cnt_inc = r_bit_count + CNT_W'(1);
    assign wr_wide = {{DATA_BITS{1'b0}}, i_write_word};
    assign wr_fit  = wr_wide[DATA_BITS-1:0];
    assign rd_wide = {{WORD_W{1'b0}}, r_data_shift};

    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_half_tick  = r_half_tick;
        n_read_mode  = r_read_mode;
        n_cmd_shift  = r_cmd_shift;
        n_data_shift = r_data_shift;
        n_clk_level  = r_clk_level;
        n_mosi       = r_mosi;

        o_result.cs_cmd_n  = 1'b1;
        o_result.cs_data_n = 1'b1;
        o_result.busy_res  = 1'b1;
        o_result.done_res  = 1'b0;
        o_result.read_word = '0;

        case (r_phase)
            PH_CMD: begin
                o_result.cs_cmd_n = 1'b0;
                if (!r_half_tick) begin
                    n_mosi      = r_cmd_shift[CMD_BITS-1];
                    n_cmd_shift = {r_cmd_shift[CMD_BITS-2:0], 1'b0};
                    n_clk_level = 1'b0;
                    n_half_tick = 1'b1;
                end else begin
                    n_clk_level = 1'b1;
                    n_half_tick = 1'b0;
                    n_bit_count = cnt_inc;
                    if (cnt_inc >= CNT_W'(CMD_BITS)) begin
                        n_bit_count = '0;
                        n_phase     = PH_GAP;
                    end
                end
            end
            PH_GAP: begin
                n_half_tick = 1'b0;
                n_bit_count = '0;
                if (r_read_mode) begin
                    n_data_shift = '0;
                    n_phase      = PH_RD;
                end else begin
                    n_phase = PH_WR;
                end
            end
            PH_WR: begin
                o_result.cs_data_n = 1'b0;
                if (!r_half_tick) begin
                    n_mosi       = r_data_shift[DATA_BITS-1];
                    n_data_shift = {r_data_shift[DATA_BITS-2:0], 1'b0};
                    n_clk_level  = 1'b0;
                    n_half_tick  = 1'b1;
                end else begin
                    n_clk_level = 1'b1;
                    n_half_tick = 1'b0;
                    n_bit_count = cnt_inc;
                    if (cnt_inc >= CNT_W'(DATA_BITS)) begin
                        n_phase = PH_FIN;
                    end
                end
            end
            PH_RD: begin
                o_result.cs_data_n = 1'b0;
                if (!r_half_tick) begin
                    n_data_shift = {r_data_shift[DATA_BITS-2:0], i_miso};
                    n_clk_level  = 1'b1;
                    n_half_tick  = 1'b1;
                end else begin
                    n_clk_level = 1'b0;
                    n_half_tick = 1'b0;
                    n_bit_count = cnt_inc;
                    if (cnt_inc >= CNT_W'(DATA_BITS)) begin
                        n_phase = PH_FIN;
                    end
                end
            end
            PH_FIN: begin
                o_result.done_res = 1'b1;
                if (r_read_mode) begin
                    o_result.read_word = rd_wide[WORD_W-1:0];
                end
                n_bit_count = '0;
                n_half_tick = 1'b0;
                n_phase     = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_start_req) begin
                    n_read_mode       = i_mode;
                    n_data_shift      = i_mode ? '0 : wr_fit;
                    n_bit_count       = '0;
                    n_phase           = PH_CMD;
                    o_result.cs_cmd_n = 1'b0;
                    n_mosi            = i_cmd_byte[CMD_BITS-1];
                    n_cmd_shift       = {i_cmd_byte[CMD_BITS-2:0], 1'b0};
                    n_clk_level       = 1'b0;
                    n_half_tick       = 1'b1;
                end else begin
                    o_result.busy_res = 1'b0;
                end
            end
        endcase

        o_result.sclk = n_clk_level;
        o_result.mosi = n_mosi;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit_count  <= '0;
            r_half_tick  <= 1'b0;
            r_read_mode  <= 1'b0;
            r_cmd_shift  <= '0;
            r_data_shift <= '0;
            r_clk_level  <= 1'b0;
            r_mosi       <= 1'b0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_half_tick  <= n_half_tick;
            r_read_mode  <= n_read_mode;
            r_cmd_shift  <= n_cmd_shift;
            r_data_shift <= n_data_shift;
            r_clk_level  <= n_clk_level;
            r_mosi       <= n_mosi;
        end
    end

    `SCDM_ASSERT(a_fin_to_idle, i_clk, i_rst_n,
        (i_accept && r_phase == PH_FIN) |=> (r_phase == PH_IDLE))
    `SCDM_ASSERT(a_half_in_shift, i_clk, i_rst_n,
        r_half_tick |-> (r_phase == PH_CMD || r_phase == PH_WR || r_phase == PH_RD))
    `SCDM_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_bit_count <= CNT_W'(DATA_BITS))

endmodule

[design/scdm_out_buf.sv]
// ----------------------------------------------------------------------------
// scdm_out_buf
// two-entry result register with skid slot, keeps order under stalls
// ----------------------------------------------------------------------------
`include "spi_cmd_data_master_defines.svh"

module scdm_out_buf import scdm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_can_push,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    pop;

    assign pop        = r_main_valid && i_ready;
    assign o_can_push = !r_skid_valid;
    assign o_valid    = r_main_valid;
    assign o_data     = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main       <= i_data;
                r_main_valid <= 1'b1;
            end else begin
                r_skid       <= i_data;
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_main_valid <= 1'b0;
        end
    end

    `SCDM_ASSERT(a_skid_needs_main, i_clk, i_rst_n,
        r_skid_valid |-> r_main_valid)
    `SCDM_ASSERT(a_skid_held, i_clk, i_rst_n,
        (r_skid_valid && !pop) |=> (r_skid_valid && $stable(r_skid)))
    `SCDM_ASSERT(a_skid_drains, i_clk, i_rst_n,
        (r_skid_valid && pop) |=> (r_main_valid && !r_skid_valid))

endmodule
